FILE: sv/jdel_pkg.sv
// ----------------------------------------------------------------------------
// jdel_pkg: shared types and constants for the joystick direction latch
// Field widths, register reset values, register indexes and action codes.
// ----------------------------------------------------------------------------
package jdel_pkg;

    localparam int SampleW   = 8;
    localparam int ThreshW   = 7;
    localparam int ActionW   = 3;
    localparam int CfgIdxW   = 2;
    localparam int CfgDataW  = 8;
    localparam int FlagW     = 5;

    // Scaling multiplies by 128, so the dividend carries seven extra bits
    localparam int ScaleShift = 7;
    localparam int NumW       = SampleW + ScaleShift;
    localparam int CntW       = $clog2(NumW);

    localparam logic [SampleW-1:0] SampleMax   = '1;
    localparam logic [SampleW-1:0] XCenterRst  = 8'd128;
    localparam logic [SampleW-1:0] YCenterRst  = 8'd128;
    localparam logic [ThreshW-1:0] ThreshRst   = 7'd100;
    localparam logic [SampleW-1:0] QuoHighMax  = 8'd128;

    localparam logic [CfgIdxW-1:0] REG_X_CENTER  = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_Y_CENTER  = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_THRESHOLD = 2'd2;

    localparam int FLAG_RIGHT = 0;
    localparam int FLAG_LEFT  = 1;
    localparam int FLAG_UP    = 2;
    localparam int FLAG_DOWN  = 3;
    localparam int FLAG_PRESS = 4;

    typedef enum logic [0:0] {
        OP_POLL = 1'b0,
        OP_TAKE = 1'b1
    } opcode_t;

    typedef enum logic [ActionW-1:0] {
        ACT_NEUTRAL = 3'd0,
        ACT_RIGHT   = 3'd1,
        ACT_LEFT    = 3'd2,
        ACT_UP      = 3'd3,
        ACT_DOWN    = 3'd4,
        ACT_PRESS   = 3'd5
    } action_t;

endpackage

FILE: sv/jdel_req_if.sv
// ----------------------------------------------------------------------------
// jdel_req_if: request channel of the joystick direction latch
// Carries poll and take transactions with the raw samples and button level.
// ----------------------------------------------------------------------------
interface jdel_req_if;

    logic                             valid;
    logic                             ready;
    logic [0:0]                       opcode;
    logic [jdel_pkg::SampleW-1:0]     raw_x;
    logic [jdel_pkg::SampleW-1:0]     raw_y;
    logic [0:0]                       button_level;

    modport source (output valid, output opcode, output raw_x, output raw_y,
                    output button_level, input ready);
    modport sink   (input valid, input opcode, input raw_x, input raw_y,
                    input button_level, output ready);

endinterface

FILE: sv/jdel_rsp_if.sv
// ----------------------------------------------------------------------------
// jdel_rsp_if: response channel of the joystick direction latch
// Carries the signed deflections and the taken action code.
// ----------------------------------------------------------------------------
interface jdel_rsp_if;

    logic                                valid;
    logic                                ready;
    logic signed [jdel_pkg::SampleW-1:0] deflection_x;
    logic signed [jdel_pkg::SampleW-1:0] deflection_y;
    logic [jdel_pkg::ActionW-1:0]        action;

    modport source (output valid, output deflection_x, output deflection_y,
                    output action, input ready);
    modport sink   (input valid, input deflection_x, input deflection_y,
                    input action, output ready);

endinterface

FILE: sv/jdel_cfg_if.sv
// ----------------------------------------------------------------------------
// jdel_cfg_if: configuration write channel of the joystick direction latch
// Carries a register index and its write data.
// ----------------------------------------------------------------------------
interface jdel_cfg_if;

    logic                          valid;
    logic                          ready;
    logic [jdel_pkg::CfgIdxW-1:0]  index;
    logic [jdel_pkg::CfgDataW-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);

endinterface

FILE: sv/joystick_direction_event_latch_top.sv
// ----------------------------------------------------------------------------
// joystick_direction_event_latch_top: calibrated joystick direction events
// Rescales X/Y samples around their centers, detects threshold crossings
// and button presses, and latches the latest event until it is taken.
// ----------------------------------------------------------------------------
// Usage
//   req : one transaction per item. opcode poll carries raw_x, raw_y and the
//         active-low button_level; opcode take reads the pending action.
//   rsp : exactly one transaction per request, in request order. A poll
//         returns both deflections and action neutral; a take returns zero
//         deflections and the pending action, which is then cleared.
//   cfg : register writes (0 x_center, 1 y_center, 2 threshold), always
//         ready; write only while no request is in flight.
// Sequencing
//   A poll runs both axis divisions side by side, one quotient bit per cycle
//   over 15 dividend bits, then updates the flags as the response is written
//   to the output register; req.ready returns in the same cycle as the
//   response becomes valid. A take skips the division. A new request is only
//   accepted once the previous one has left the bit-serial divider path.
// Reset
//   Centers return to 128, threshold to 100, flags and pending action clear.
// Stalls
//   The response sits in an output register; one more request is accepted
//   and worked on while it waits, then the block holds until rsp.ready.
// ----------------------------------------------------------------------------
module joystick_direction_event_latch_top (
    input  logic        clk,
    input  logic        rst_n,
    jdel_req_if.sink    req,
    jdel_rsp_if.source  rsp,
    jdel_cfg_if.sink    cfg
);

    localparam int SW = jdel_pkg::SampleW;
    localparam int NW = jdel_pkg::NumW;
    localparam int CW = jdel_pkg::CntW;
    localparam int TW = jdel_pkg::ThreshW;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIN
    } state_t;

    state_t                          state_reg, state_next;
    logic [CW-1:0]                   cnt_reg, cnt_next;
    jdel_pkg::opcode_t               op_reg, op_next;
    logic                            btn_reg, btn_next;

    // Per-axis divider lanes: 0 is X, 1 is Y
    logic [NW-1:0]                   num_reg [2];
    logic [NW-1:0]                   num_next [2];
    logic [SW-1:0]                   rem_reg [2];
    logic [SW-1:0]                   rem_next [2];
    logic [SW-1:0]                   quo_reg [2];
    logic [SW-1:0]                   quo_next [2];
    logic [SW-1:0]                   den_reg [2];
    logic [SW-1:0]                   den_next [2];
    logic [1:0]                      hi_reg, hi_next;
    logic [1:0]                      sat_reg, sat_next;

    logic [SW-1:0]                   xc_reg, xc_next;
    logic [SW-1:0]                   yc_reg, yc_next;
    logic [TW-1:0]                   th_reg, th_next;
    logic [jdel_pkg::FlagW-1:0]      flags_reg, flags_next;
    jdel_pkg::action_t               pending_reg, pending_next;

    logic                            out_valid_reg, out_valid_next;
    logic signed [SW-1:0]            out_dx_reg, out_dx_next;
    logic signed [SW-1:0]            out_dy_reg, out_dy_next;
    jdel_pkg::action_t               out_act_reg, out_act_next;

    logic                            req_fire;
    logic                            out_write;
    logic [SW-1:0]                   sample [2];
    logic [SW-1:0]                   center [2];
    logic [SW:0]                     trial [2];
    logic [SW:0]                     diff [2];
    logic                            ge [2];
    logic [SW-1:0]                   scaled [2];
    logic signed [SW-1:0]            defl [2];
    logic signed [SW:0]              defl_ext [2];
    logic signed [SW:0]              th_ext;
    logic signed [SW:0]              neg_sum [2];
    logic [jdel_pkg::FlagW-1:0]      cond;
    logic [jdel_pkg::FlagW-1:0]      rise;

    assign req.ready    = (state_reg == ST_IDLE);
    assign req_fire     = req.valid && req.ready;
    assign cfg.ready    = 1'b1;

    assign rsp.valid        = out_valid_reg;
    assign rsp.deflection_x = out_dx_reg;
    assign rsp.deflection_y = out_dy_reg;
    assign rsp.action       = out_act_reg;

    assign out_write = (state_reg == ST_FIN) && (!out_valid_reg || rsp.ready);

    assign sample[0] = req.raw_x;
    assign sample[1] = req.raw_y;
    assign center[0] = xc_reg;
    assign center[1] = yc_reg;
    assign th_ext    = $signed({2'b00, th_reg});

    // Restoring division step and final scaling per lane
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            trial[i]    = {rem_reg[i], num_reg[i][NW-1]};
            diff[i]     = trial[i] - {1'b0, den_reg[i]};
            ge[i]       = (trial[i] >= {1'b0, den_reg[i]});
            if (sat_reg[i])
                scaled[i] = jdel_pkg::SampleMax;
            else if (hi_reg[i])
                scaled[i] = jdel_pkg::SampleMax - quo_reg[i];
            else
                scaled[i] = quo_reg[i];
            // Subtract 128 by flipping the top bit
            defl[i]     = $signed({~scaled[i][SW-1], scaled[i][SW-2:0]});
            defl_ext[i] = $signed({defl[i][SW-1], defl[i]});
            neg_sum[i]  = defl_ext[i] + th_ext;
        end
    end

    always_comb
    begin
        cond = '0;
        cond[jdel_pkg::FLAG_RIGHT] = (defl_ext[0] > th_ext);
        cond[jdel_pkg::FLAG_LEFT]  = (neg_sum[0] < $signed({(SW+1){1'b0}}));
        cond[jdel_pkg::FLAG_UP]    = (defl_ext[1] > th_ext);
        cond[jdel_pkg::FLAG_DOWN]  = (neg_sum[1] < $signed({(SW+1){1'b0}}));
        cond[jdel_pkg::FLAG_PRESS] = !btn_reg;
        rise = cond & ~flags_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        op_next        = op_reg;
        btn_next       = btn_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        den_next       = den_reg;
        hi_next        = hi_reg;
        sat_next       = sat_reg;
        xc_next        = xc_reg;
        yc_next        = yc_reg;
        th_next        = th_reg;
        flags_next     = flags_reg;
        pending_next   = pending_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_dx_next    = out_dx_reg;
        out_dy_next    = out_dy_reg;
        out_act_next   = out_act_reg;

        if (cfg.valid)
        begin
            unique case (cfg.index)
                jdel_pkg::REG_X_CENTER:  xc_next = cfg.data;
                jdel_pkg::REG_Y_CENTER:  yc_next = cfg.data;
                jdel_pkg::REG_THRESHOLD: th_next = cfg.data[TW-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    op_next  = jdel_pkg::opcode_t'(req.opcode);
                    btn_next = req.button_level[0];
                    cnt_next = '0;
                    for (int i = 0; i < 2; i++)
                    begin
                        rem_next[i] = '0;
                        quo_next[i] = '0;
                        if (sample[i] < center[i])
                        begin
                            num_next[i] = {sample[i], {jdel_pkg::ScaleShift{1'b0}}};
                            den_next[i] = center[i];
                            hi_next[i]  = 1'b0;
                            sat_next[i] = 1'b0;
                        end
                        else
                        begin
                            num_next[i] = {jdel_pkg::SampleMax - sample[i],
                                           {jdel_pkg::ScaleShift{1'b0}}};
                            den_next[i] = jdel_pkg::SampleMax - center[i];
                            hi_next[i]  = 1'b1;
                            // Zero divisor: the scaled value is pinned at full scale
                            sat_next[i] = (center[i] == jdel_pkg::SampleMax);
                        end
                    end
                    if (jdel_pkg::opcode_t'(req.opcode) == jdel_pkg::OP_TAKE)
                        state_next = ST_FIN;
                    else
                        state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                for (int i = 0; i < 2; i++)
                begin
                    rem_next[i] = ge[i] ? diff[i][SW-1:0] : trial[i][SW-1:0];
                    quo_next[i] = {quo_reg[i][SW-2:0], ge[i]};
                    num_next[i] = {num_reg[i][NW-2:0], 1'b0};
                end
                if (cnt_reg == CW'(NW - 1))
                    state_next = ST_FIN;
                else
                    cnt_next = cnt_reg + 1'b1;
            end

            ST_FIN:
            begin
                if (out_write)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    if (op_reg == jdel_pkg::OP_TAKE)
                    begin
                        out_dx_next  = '0;
                        out_dy_next  = '0;
                        out_act_next = pending_reg;
                        pending_next = jdel_pkg::ACT_NEUTRAL;
                    end
                    else
                    begin
                        out_dx_next  = defl[0];
                        out_dy_next  = defl[1];
                        out_act_next = jdel_pkg::ACT_NEUTRAL;
                        flags_next   = cond;
                        // Among crossings that rise together, press wins, then down, up, left, right
                        priority if (rise[jdel_pkg::FLAG_PRESS])
                            pending_next = jdel_pkg::ACT_PRESS;
                        else if (rise[jdel_pkg::FLAG_DOWN])
                            pending_next = jdel_pkg::ACT_DOWN;
                        else if (rise[jdel_pkg::FLAG_UP])
                            pending_next = jdel_pkg::ACT_UP;
                        else if (rise[jdel_pkg::FLAG_LEFT])
                            pending_next = jdel_pkg::ACT_LEFT;
                        else if (rise[jdel_pkg::FLAG_RIGHT])
                            pending_next = jdel_pkg::ACT_RIGHT;
                        else
                            pending_next = pending_reg;
                    end
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            op_reg        <= jdel_pkg::OP_POLL;
            btn_reg       <= 1'b1;
            for (int i = 0; i < 2; i++)
            begin
                num_reg[i] <= '0;
                rem_reg[i] <= '0;
                quo_reg[i] <= '0;
                den_reg[i] <= '0;
            end
            hi_reg        <= '0;
            sat_reg       <= '0;
            xc_reg        <= jdel_pkg::XCenterRst;
            yc_reg        <= jdel_pkg::YCenterRst;
            th_reg        <= jdel_pkg::ThreshRst;
            flags_reg     <= '0;
            pending_reg   <= jdel_pkg::ACT_NEUTRAL;
            out_valid_reg <= 1'b0;
            out_dx_reg    <= '0;
            out_dy_reg    <= '0;
            out_act_reg   <= jdel_pkg::ACT_NEUTRAL;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            op_reg        <= op_next;
            btn_reg       <= btn_next;
            num_reg       <= num_next;
            rem_reg       <= rem_next;
            quo_reg       <= quo_next;
            den_reg       <= den_next;
            hi_reg        <= hi_next;
            sat_reg       <= sat_next;
            xc_reg        <= xc_next;
            yc_reg        <= yc_next;
            th_reg        <= th_next;
            flags_reg     <= flags_next;
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
            out_dx_reg    <= out_dx_next;
            out_dy_reg    <= out_dy_next;
            out_act_reg   <= out_act_next;
        end
    end

    // A response is either a poll (no action) or a take (no deflection)
    a_rsp_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_act_reg == jdel_pkg::ACT_NEUTRAL)
                          || (out_dx_reg == '0 && out_dy_reg == '0))
        else $error("response mixes action and deflection");

    // A completed take leaves nothing pending
    a_take_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_write && op_reg == jdel_pkg::OP_TAKE)
        |=> (pending_reg == jdel_pkg::ACT_NEUTRAL))
        else $error("pending action survived a take");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (cnt_reg <= CW'(NW - 1)))
        else $error("divider step count overrun");

    // Partial remainder stays below the divisor on every live lane
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV)
        |-> (sat_reg[0] || rem_reg[0] < den_reg[0])
            && (sat_reg[1] || rem_reg[1] < den_reg[1]))
        else $error("divider remainder out of range");

    // Above-center quotient never exceeds 128, so 255 - q cannot wrap
    a_quo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && op_reg == jdel_pkg::OP_POLL)
        |-> (!hi_reg[0] || sat_reg[0] || quo_reg[0] <= jdel_pkg::QuoHighMax)
            && (!hi_reg[1] || sat_reg[1] || quo_reg[1] <= jdel_pkg::QuoHighMax))
        else $error("scaled quotient out of range");

endmodule
